// File: design/mts_pkg.sv
`default_nettype none

package mts_pkg;

   // Default number of entries in the stack
   localparam int DefaultStackDepth = 64;

   localparam int WordWidth   = 32;
   localparam int StatusWidth = 2;

   typedef logic signed [WordWidth-1:0]   word_type;
   typedef logic        [StatusWidth-1:0] status_type;

   // Request opcodes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Result status codes
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_OVERFLOW  = 2'd1;
   localparam status_type STATUS_UNDERFLOW = 2'd2;

   // One stack level: the value and the running minimum at or below it
   typedef struct packed {
      word_type value;
      word_type min;
   } entry_type;

   // Shift control broadcast to every cell
   typedef struct packed {
      logic push;   // shift toward the bottom, cell 0 loads the new entry
      logic pop;    // shift toward the top
   } shift_ctl_type;

endpackage

`default_nettype wire

// File: design/mts_cell.sv
`default_nettype none

// One level of the stack. Loads from the level above on push and from the
// level below on pop, otherwise holds.
module mts_cell (
   input  wire                    clock,
   input  mts_pkg::shift_ctl_type ctl,
   input  mts_pkg::entry_type     from_above,
   input  mts_pkg::entry_type     from_below,
   output mts_pkg::entry_type     entry
);
   import mts_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Next entry select
   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         entry_in = from_above;
      end else if (ctl.pop) begin
         entry_in = from_below;
      end
   end

   // Payload only, no reset needed
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// File: design/min_tracking_stack.sv
`default_nettype none

// Min-tracking stack built as a chain of STACK_DEPTH shift cells, with the
// top of the stack in cell 0. A push shifts every cell down one level and
// loads the new value with its running minimum into cell 0; a pop shifts
// every cell up one level. Each request beat yields exactly one response
// beat in the following cycle, from a single output register; a new request is
// taken every cycle while that register is empty or being drained, so the
// block sustains one operation per clock. Push onto a full stack reports
// overflow and pop from an empty stack reports underflow; both leave the
// stack untouched. Top and minimum read as zero while the stack is empty.
module min_tracking_stack #(
   parameter int STACK_DEPTH = mts_pkg::DefaultStackDepth,
   parameter int CountWidth  = $clog2(STACK_DEPTH + 1)
) (
   input  wire                     clock,
   input  wire                     reset,

   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire                     req_cmd,
   input  mts_pkg::word_type       req_push_value,

   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output mts_pkg::word_type       rsp_top_value,
   output mts_pkg::word_type       rsp_min_value,
   output logic [CountWidth-1:0]   rsp_entry_count,
   output logic                    rsp_is_empty,
   output mts_pkg::status_type     rsp_status
);
   import mts_pkg::*;

   localparam logic [CountWidth-1:0] FullCount = CountWidth'(STACK_DEPTH);

   logic                  accept;
   logic                  is_full;
   logic                  is_zero;
   shift_ctl_type         ctl;
   entry_type             new_entry;
   entry_type             cell_q [STACK_DEPTH];
   entry_type             top_entry;
   entry_type             result_entry;
   status_type            result_status;

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   entry_type             rsp_entry_ff;
   entry_type             rsp_entry_in;
   logic [CountWidth-1:0] rsp_count_ff;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;

   // Handshake: output register frees up when empty or drained this cycle
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_full = (count_ff == FullCount);
   assign is_zero = (count_ff == '0);

   // New entry: minimum with the level below, ties keep the old minimum
   always_comb begin
      new_entry.value = req_push_value;
      new_entry.min   = req_push_value;
      if (!is_zero && !($signed(req_push_value) < $signed(cell_q[0].min))) begin
         new_entry.min = cell_q[0].min;
      end
   end

   // Operation decode
   always_comb begin
      ctl.push      = 1'b0;
      ctl.pop       = 1'b0;
      count_in      = count_ff;
      result_status = STATUS_OK;
      top_entry     = cell_q[0];
      if (accept) begin
         unique case (req_cmd)
            CMD_PUSH: begin
               if (is_full) begin
                  result_status = STATUS_OVERFLOW;
               end else begin
                  ctl.push  = 1'b1;
                  count_in  = count_ff + 1'b1;
                  top_entry = new_entry;
               end
            end
            CMD_POP: begin
               if (is_zero) begin
                  result_status = STATUS_UNDERFLOW;
               end else begin
                  ctl.pop   = 1'b1;
                  count_in  = count_ff - 1'b1;
                  top_entry = cell_q[1];
               end
            end
            default: begin
               result_status = STATUS_OK;
            end
         endcase
      end
   end

   // Empty stack reads as zero
   always_comb begin
      result_entry = top_entry;
      if (count_in == '0) begin
         result_entry = '0;
      end
   end

   // Cell chain
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      entry_type above;
      entry_type below;
      if (i == 0) begin : g_first
         assign above = new_entry;
      end else begin : g_rest
         assign above = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = cell_q[i];
      end else begin : g_inner
         assign below = cell_q[i+1];
      end
      mts_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .from_above (above),
         .from_below (below),
         .entry      (cell_q[i])
      );
   end

   // Output register next state
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_entry_in  = rsp_entry_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_entry_in  = result_entry;
         rsp_status_in = result_status;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_entry_ff  <= rsp_entry_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = rsp_entry_ff.value;
   assign rsp_min_value   = rsp_entry_ff.min;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = (rsp_count_ff == '0);
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

// File: design/mts_checker.sv
`default_nettype none

module mts_checker #(
   parameter int CountWidth = 7
) (
   input wire                    clock,
   input wire                    reset,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input wire [31:0]             rsp_top_value,
   input wire [31:0]             rsp_min_value,
   input wire [CountWidth-1:0]   rsp_entry_count,
   input wire                    rsp_is_empty,
   input wire [1:0]              rsp_status
);
   import mts_pkg::*;

   // Stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_top_value)
         && $stable(rsp_min_value) && $stable(rsp_entry_count) && $stable(rsp_status))
      else $error("response changed while stalled");

   // Empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   // Empty stack reports zero top and minimum
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_top_value == '0) && (rsp_min_value == '0))
      else $error("empty stack reports nonzero data");

   // Minimum never exceeds the top value
   a_min_le_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_empty |-> !($signed(rsp_top_value) < $signed(rsp_min_value)))
      else $error("minimum above top value");

   // Underflow only with an empty stack
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_UNDERFLOW) |-> rsp_is_empty)
      else $error("underflow reported on a nonempty stack");

endmodule

bind min_tracking_stack mts_checker #(.CountWidth(CountWidth)) u_mts_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_top_value   (rsp_top_value),
   .rsp_min_value   (rsp_min_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_status      (rsp_status)
);

`default_nettype wire
